FILE: rtl/core/bsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder package
// Constants, status codes, result word type and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_GENERATOR = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ESCAPE = 3'd1,
        ST_TOO_SHORT  = 3'd2,
        ST_CRC_ERROR  = 3'd3,
        ST_TOO_LONG   = 3'd4
    } status_t;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] frame_length;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } core_result_t;

    // CRC-16/CCITT-FALSE, MSB first, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_GENERATOR;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/bsfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder channels
// Valid/ready channels for line bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface bsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

interface bsfd_out_if;
    logic        valid;
    logic        ready;
    logic        is_end;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] frame_length;

    modport source (output valid, output is_end, output payload_byte, output status,
                    output frame_length, input ready);
    modport sink   (input valid, input is_end, input payload_byte, input status,
                    input frame_length, output ready);
endinterface

FILE: rtl/core/byte_stuffed_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder top level
// Input register, decoder core and result register on valid/ready channels.
// ----------------------------------------------------------------------------
// Path: an accepted line byte is registered in the input register, and its result word in the result register.
// Throughput: one line byte per cycle; the input register drains whenever the
// result register is empty or being taken, so ready drops only under a stall.
// Reset: asynchronous, active low; hunts for a flag, max_payload returns to 256.
module byte_stuffed_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    bsfd_in_if.sink     line_in,
    bsfd_out_if.source  frame_out
);
    import bsfd_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    result_t      out_data_reg;
    logic         process;
    core_result_t core_res;

    assign process       = in_valid_reg && (!out_valid_reg || frame_out.ready);
    assign line_in.ready = !in_valid_reg || process;

    bsfd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (process),
        .line_byte   (in_byte_reg),
        .result      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (line_in.ready)
            begin
                in_valid_reg <= line_in.valid;
            end
            if (process && core_res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_in.valid && line_in.ready)
        begin
            in_byte_reg <= line_in.line_byte;
        end
        if (process && core_res.valid)
        begin
            out_data_reg <= core_res.data;
        end
    end

    assign frame_out.valid        = out_valid_reg;
    assign frame_out.is_end       = out_data_reg.is_end;
    assign frame_out.payload_byte = out_data_reg.payload_byte;
    assign frame_out.status       = out_data_reg.status;
    assign frame_out.frame_length = out_data_reg.frame_length;

endmodule

FILE: rtl/core/bsfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder core
// Frame state, unstuffing, CRC, two-byte delay and end-of-frame status.
// ----------------------------------------------------------------------------
module bsfd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  step,
    input  logic [7:0]            line_byte,
    output bsfd_pkg::core_result_t result
);
    import bsfd_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic        esc_pend_reg, esc_pend_next;
    logic        esc_err_reg, esc_err_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  delay0_reg, delay0_next;
    logic [7:0]  delay1_reg, delay1_next;
    logic [1:0]  fill_reg, fill_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] max_payload_reg;

    logic        push;
    logic [7:0]  data_byte;
    logic [7:0]  unesc_byte;
    status_t     end_status;

    assign unesc_byte = line_byte ^ ESC_XOR;

    always_comb
    begin
        if (esc_err_reg || esc_pend_reg)
        begin
            end_status = ST_BAD_ESCAPE;
        end
        else if (fill_reg != 2'd2)
        begin
            end_status = ST_TOO_SHORT;
        end
        else if (crc_reg != 16'd0)
        begin
            end_status = ST_CRC_ERROR;
        end
        else if (count_reg > max_payload_reg)
        begin
            end_status = ST_TOO_LONG;
        end
        else
        begin
            end_status = ST_OK;
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        esc_err_next  = esc_err_reg;
        crc_next      = crc_reg;
        delay0_next   = delay0_reg;
        delay1_next   = delay1_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        push          = 1'b0;
        data_byte     = line_byte;
        result        = '0;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (line_byte == FLAG_BYTE)
                begin
                    in_frame_next = 1'b1;
                    esc_pend_next = 1'b0;
                    esc_err_next  = 1'b0;
                    crc_next      = CRC_INIT;
                    delay0_next   = '0;
                    delay1_next   = '0;
                    fill_next     = '0;
                    count_next    = '0;
                end
            end
            else if (line_byte == FLAG_BYTE)
            begin
                // idle flag when nothing arrived since the opening flag
                if (fill_reg != 2'd0 || esc_pend_reg || esc_err_reg)
                begin
                    result.valid             = 1'b1;
                    result.data.is_end       = 1'b1;
                    result.data.status       = end_status;
                    result.data.frame_length = count_reg;
                    esc_pend_next = 1'b0;
                    esc_err_next  = 1'b0;
                    crc_next      = CRC_INIT;
                    delay0_next   = '0;
                    delay1_next   = '0;
                    fill_next     = '0;
                    count_next    = '0;
                end
            end
            else if (esc_pend_reg)
            begin
                esc_pend_next = 1'b0;
                data_byte     = unesc_byte;
                push          = 1'b1;
                if (unesc_byte != FLAG_BYTE && unesc_byte != ESC_BYTE)
                begin
                    esc_err_next = 1'b1;
                end
            end
            else if (line_byte == ESC_BYTE)
            begin
                esc_pend_next = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end

        if (push)
        begin
            crc_next = crc_update(crc_reg, data_byte);
            if (fill_reg == 2'd2)
            begin
                // emit the oldest byte; the last two stay back as CRC candidates
                result.valid             = 1'b1;
                result.data.payload_byte = delay0_reg;
                delay0_next              = delay1_reg;
                delay1_next              = data_byte;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            else
            begin
                if (fill_reg[0])
                begin
                    delay1_next = data_byte;
                end
                else
                begin
                    delay0_next = data_byte;
                end
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            esc_pend_reg    <= 1'b0;
            esc_err_reg     <= 1'b0;
            crc_reg         <= CRC_INIT;
            delay0_reg      <= '0;
            delay1_reg      <= '0;
            fill_reg        <= '0;
            count_reg       <= '0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
            esc_err_reg  <= esc_err_next;
            crc_reg      <= crc_next;
            delay0_reg   <= delay0_next;
            delay1_reg   <= delay1_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: rtl/core/bsfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
module bsfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_end,
    input logic [7:0]  payload_byte,
    input logic [2:0]  status,
    input logic [15:0] frame_length
);
    import bsfd_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_end) && $stable(payload_byte)
            && $stable(status) && $stable(frame_length))
        else $error("result word changed while stalled");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> status == ST_OK && frame_length == 16'd0)
        else $error("payload word carries end fields");

    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end && status == ST_TOO_SHORT |-> frame_length == 16'd0)
        else $error("short frame with nonzero length");

    a_long_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end && status == ST_TOO_LONG |-> frame_length != 16'd0
            && payload_byte == 8'd0)
        else $error("too-long frame with bad length or byte");

endmodule

bind byte_stuffed_frame_decoder_top bsfd_checker u_bsfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (frame_out.valid),
    .out_ready    (frame_out.ready),
    .is_end       (frame_out.is_end),
    .payload_byte (frame_out.payload_byte),
    .status       (frame_out.status),
    .frame_length (frame_out.frame_length)
);
